FILE: rtl/rhs_pkg.sv
`default_nettype none

package rhs_pkg;

   // fixed field widths
   localparam int VALUE_W    = 32;
   localparam int NB_W       = 7;
   localparam int FRAC_W     = 17;
   localparam int READ_BIN_W = 6;
   localparam int OUT_W      = 32;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 3;

   // divider geometry: quotient never exceeds bin count minus one
   localparam int QUOT_W    = NB_W;
   localparam int PROD_W    = VALUE_W + NB_W;
   localparam int DIV_CNT_W = 3;

   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
   localparam logic [OUT_W-1:0]  OUT_MAX  = '1;

   // command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_FRAC  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_FRAC = 3'd4;

   // decoded configuration seen by the sequencer
   typedef struct packed {
      logic signed [VALUE_W-1:0] range_min;
      logic signed [VALUE_W-1:0] range_max;
      logic [NB_W-1:0]           nb;
      logic [NB_W-1:0]           split_lo;
      logic [NB_W-1:0]           split_hi;
   } cfg_type;

endpackage

`default_nettype wire

FILE: rtl/range_histogram_with_split.sv
// Histogram engine with range binning and a three-way split of the bins.
// Request channel (req_valid / req_stall): a command word with a sample
// value and a bin index. Clear empties all bins, add bins one sample,
// read returns one word on the response channel (rsp_valid / rsp_stall).
// Configuration channel (csr_valid / csr_ready): range, bin count and the
// two split fractions. The user must write them only while the block is
// idle; the block does not enforce this, and csr_ready is always high.
// One request is in work at a time; req_stall is high until it finishes.
// Clear: one bin written per cycle over all BINS bins. Add: a multiply
// step, then the compare/subtract divider loop that turns the offset into
// a bin index, then a read-modify-write. Read: one bin per cycle through
// the memory read port into a single shared saturating adder for the three
// totals. Reset: the configuration returns to its defaults and a clearing
// pass runs through the bin memory, with req_stall high.
// The response word sits in an output register; while rsp_stall holds it,
// clear and add requests proceed, and a further read waits at its end.

`default_nettype none

module range_histogram_with_split #(
   parameter int BINS        = 64,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [rhs_pkg::CMD_W-1:0]         req_command,
   input  wire logic signed [rhs_pkg::VALUE_W-1:0] req_sample_value,
   input  wire logic [rhs_pkg::READ_BIN_W-1:0]    req_read_bin,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [rhs_pkg::OUT_W-1:0]              rsp_bin_value,
   output logic [rhs_pkg::OUT_W-1:0]              rsp_peak_count,
   output logic [rhs_pkg::OUT_W-1:0]              rsp_below_total,
   output logic [rhs_pkg::OUT_W-1:0]              rsp_selected_total,
   output logic [rhs_pkg::OUT_W-1:0]              rsp_above_total,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [rhs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rhs_pkg::VALUE_W-1:0]       csr_data
);

   localparam int ADDR_W = $clog2(BINS);
   localparam int CMP_W  = (ADDR_W > rhs_pkg::NB_W) ? ADDR_W : rhs_pkg::NB_W;
   localparam int OW     = rhs_pkg::OUT_W;

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_MUL    = 8'b0000_0100,
      ST_DIV    = 8'b0000_1000,
      ST_FETCH  = 8'b0001_0000,
      ST_UPDATE = 8'b0010_0000,
      ST_SCAN   = 8'b0100_0000,
      ST_LOAD   = 8'b1000_0000
   } state_type;

   function automatic logic [OW-1:0] out_sat(input logic [COUNT_WIDTH-1:0] v);
      logic [COUNT_WIDTH+OW-1:0] w;
      w = (COUNT_WIDTH + OW)'(v);
      return (w > (COUNT_WIDTH + OW)'(rhs_pkg::OUT_MAX)) ? rhs_pkg::OUT_MAX : w[OW-1:0];
   endfunction

   rhs_pkg::cfg_type cfg;

   state_type                        state_ff, state_in;
   logic [ADDR_W-1:0]                addr_ff, addr_in;
   logic                             rdv_ff, rdv_in;
   logic [ADDR_W-1:0]                rdi_ff, rdi_in;
   logic [rhs_pkg::VALUE_W-1:0]      off_ff, off_in;
   logic [rhs_pkg::VALUE_W-1:0]      span_ff, span_in;
   logic [rhs_pkg::READ_BIN_W-1:0]   rb_ff, rb_in;
   logic [COUNT_WIDTH-1:0]           peak_ff, peak_in;
   logic [COUNT_WIDTH-1:0]           below_ff, below_in;
   logic [COUNT_WIDTH-1:0]           sel_ff, sel_in;
   logic [COUNT_WIDTH-1:0]           above_ff, above_in;
   logic [COUNT_WIDTH-1:0]           binv_ff, binv_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]                    rsp_bin_ff, rsp_bin_in;
   logic [OW-1:0]                    rsp_peak_ff, rsp_peak_in;
   logic [OW-1:0]                    rsp_below_ff, rsp_below_in;
   logic [OW-1:0]                    rsp_sel_ff, rsp_sel_in;
   logic [OW-1:0]                    rsp_above_ff, rsp_above_in;

   logic                             req_accept;
   logic signed [rhs_pkg::VALUE_W:0] sample_ext;
   logic signed [rhs_pkg::VALUE_W:0] min_ext;
   logic signed [rhs_pkg::VALUE_W:0] max_ext;
   logic signed [rhs_pkg::VALUE_W:0] off_full;
   logic signed [rhs_pkg::VALUE_W:0] span_full;
   logic                             in_range;
   logic [rhs_pkg::NB_W-1:0]         nb_last;

   logic                             div_start;
   logic [rhs_pkg::PROD_W-1:0]       div_numer;
   logic                             div_done;
   logic [rhs_pkg::QUOT_W-1:0]       div_quot;

   logic                             mem_wr_en;
   logic [ADDR_W-1:0]                mem_wr_addr;
   logic [COUNT_WIDTH-1:0]           mem_wr_data;
   logic [ADDR_W-1:0]                mem_rd_addr;
   logic [COUNT_WIDTH-1:0]           mem_rd_data;

   logic [CMP_W-1:0]                 rdi_cmp;
   logic                             in_below;
   logic                             in_sel;
   logic [COUNT_WIDTH-1:0]           acc_cur;
   logic [COUNT_WIDTH:0]             acc_sum;
   logic [COUNT_WIDTH-1:0]           acc_new;
   logic                             slot_free;

   rhs_csr #(
      .BINS(BINS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rhs_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (span_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   rhs_bin_mem #(
      .BINS        (BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign nb_last    = cfg.nb - 1'b1;

   // range check and offset of an incoming sample
   always_comb begin
      sample_ext = {req_sample_value[rhs_pkg::VALUE_W-1], req_sample_value};
      min_ext    = {cfg.range_min[rhs_pkg::VALUE_W-1], cfg.range_min};
      max_ext    = {cfg.range_max[rhs_pkg::VALUE_W-1], cfg.range_max};
      off_full   = sample_ext - min_ext;
      span_full  = max_ext - min_ext;
      in_range   = (max_ext > min_ext) && (sample_ext >= min_ext) && (sample_ext <= max_ext);
   end

   // offset times (bins - 1), registered inside the divider
   assign div_start = (state_ff == ST_MUL);
   assign div_numer = rhs_pkg::PROD_W'(off_ff) * rhs_pkg::PROD_W'(nb_last);

   // zone of the bin coming back from memory, one shared saturating adder
   always_comb begin
      rdi_cmp  = CMP_W'(rdi_ff);
      in_below = (rdi_cmp < CMP_W'(cfg.split_lo));
      in_sel   = !in_below && (rdi_cmp < CMP_W'(cfg.split_hi));
      if (in_below) begin
         acc_cur = below_ff;
      end else if (in_sel) begin
         acc_cur = sel_ff;
      end else begin
         acc_cur = above_ff;
      end
      acc_sum = (COUNT_WIDTH + 1)'(acc_cur) + (COUNT_WIDTH + 1)'(mem_rd_data);
      acc_new = acc_sum[COUNT_WIDTH] ? '1 : acc_sum[COUNT_WIDTH-1:0];
   end

   // memory port steering
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = '0;
      mem_rd_addr = addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         ST_FETCH: begin
            mem_rd_addr = ADDR_W'(div_quot);
         end
         ST_UPDATE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ADDR_W'(div_quot);
            mem_wr_data = (&mem_rd_data) ? mem_rd_data : mem_rd_data + COUNT_WIDTH'(1);
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      rdv_in       = 1'b0;
      rdi_in       = addr_ff;
      off_in       = off_ff;
      span_in      = span_ff;
      rb_in        = rb_ff;
      peak_in      = peak_ff;
      below_in     = below_ff;
      sel_in       = sel_ff;
      above_in     = above_ff;
      binv_in      = binv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_bin_in   = rsp_bin_ff;
      rsp_peak_in  = rsp_peak_ff;
      rsp_below_in = rsp_below_ff;
      rsp_sel_in   = rsp_sel_ff;
      rsp_above_in = rsp_above_ff;

      // fold the bin read last cycle into the totals
      if (rdv_ff) begin
         if (mem_rd_data > peak_ff) begin
            peak_in = mem_rd_data;
         end
         if (in_below) begin
            below_in = acc_new;
         end else if (in_sel) begin
            sel_in = acc_new;
         end else begin
            above_in = acc_new;
         end
         if (rdi_cmp == CMP_W'(rb_ff)) begin
            binv_in = mem_rd_data;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == ADDR_W'(BINS - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_command)
                  rhs_pkg::CMD_CLEAR: begin
                     addr_in  = '0;
                     state_in = ST_CLEAR;
                  end
                  rhs_pkg::CMD_ADD: begin
                     if (in_range) begin
                        off_in   = off_full[rhs_pkg::VALUE_W-1:0];
                        span_in  = span_full[rhs_pkg::VALUE_W-1:0];
                        state_in = ST_MUL;
                     end
                  end
                  rhs_pkg::CMD_READ: begin
                     rb_in    = req_read_bin;
                     addr_in  = '0;
                     peak_in  = '0;
                     below_in = '0;
                     sel_in   = '0;
                     above_in = '0;
                     binv_in  = '0;
                     state_in = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            rdv_in  = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (CMP_W'(addr_ff) == CMP_W'(nb_last)) begin
               addr_in  = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!rdv_ff && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_bin_in   = out_sat(binv_ff);
               rsp_peak_in  = out_sat(peak_ff);
               rsp_below_in = out_sat(below_ff);
               rsp_sel_in   = out_sat(sel_ff);
               rsp_above_in = out_sat(above_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rdi_ff       <= rdi_in;
      off_ff       <= off_in;
      span_ff      <= span_in;
      rb_ff        <= rb_in;
      peak_ff      <= peak_in;
      below_ff     <= below_in;
      sel_ff       <= sel_in;
      above_ff     <= above_in;
      binv_ff      <= binv_in;
      rsp_bin_ff   <= rsp_bin_in;
      rsp_peak_ff  <= rsp_peak_in;
      rsp_below_ff <= rsp_below_in;
      rsp_sel_ff   <= rsp_sel_in;
      rsp_above_ff <= rsp_above_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bin_value      = rsp_bin_ff;
   assign rsp_peak_count     = rsp_peak_ff;
   assign rsp_below_total    = rsp_below_ff;
   assign rsp_selected_total = rsp_sel_ff;
   assign rsp_above_total    = rsp_above_ff;

`ifndef SYNTHESIS
   // a response word only appears at the end of a read scan
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_LOAD))
      else $error("response raised outside the load step");

   // divider finishes only while the sequencer waits on it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider done outside the divide step");

   // the computed bin index stays inside the bins in use
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (CMP_W'(div_quot) < CMP_W'(cfg.nb)))
      else $error("bin index beyond bin count");
`endif

endmodule

`default_nettype wire

FILE: rtl/rhs_csr.sv
`default_nettype none

module rhs_csr #(
   parameter int BINS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rhs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rhs_pkg::VALUE_W-1:0]     csr_data,
   output rhs_pkg::cfg_type                     cfg
);

   logic signed [rhs_pkg::VALUE_W-1:0] range_min_ff, range_min_in;
   logic signed [rhs_pkg::VALUE_W-1:0] range_max_ff, range_max_in;
   logic [rhs_pkg::NB_W-1:0]           bin_count_ff, bin_count_in;
   logic [rhs_pkg::FRAC_W-1:0]         low_frac_ff, low_frac_in;
   logic [rhs_pkg::FRAC_W-1:0]         high_frac_ff, high_frac_in;
   logic [rhs_pkg::NB_W-1:0]           split_lo_ff, split_lo_in;
   logic [rhs_pkg::NB_W-1:0]           split_hi_ff, split_hi_in;

   logic [rhs_pkg::NB_W-1:0]   nb;
   logic [rhs_pkg::FRAC_W-1:0] lo_c;
   logic [rhs_pkg::FRAC_W-1:0] hi_c;
   logic [23:0]                lo_prod;
   logic [23:0]                hi_prod;

   assign csr_ready = 1'b1;

   // register writes
   always_comb begin
      range_min_in = range_min_ff;
      range_max_in = range_max_ff;
      bin_count_in = bin_count_ff;
      low_frac_in  = low_frac_ff;
      high_frac_in = high_frac_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rhs_pkg::CSR_RANGE_MIN: range_min_in = csr_data;
            rhs_pkg::CSR_RANGE_MAX: range_max_in = csr_data;
            rhs_pkg::CSR_BIN_COUNT: bin_count_in = csr_data[rhs_pkg::NB_W-1:0];
            rhs_pkg::CSR_LOW_FRAC:  low_frac_in  = csr_data[rhs_pkg::FRAC_W-1:0];
            rhs_pkg::CSR_HIGH_FRAC: high_frac_in = csr_data[rhs_pkg::FRAC_W-1:0];
            default: ;
         endcase
      end
   end

   // effective bin count clamped to at least 3 and to the storage
   always_comb begin
      if (bin_count_ff < 7'd3) begin
         nb = 7'd3;
      end else if (32'(bin_count_ff) > BINS) begin
         nb = rhs_pkg::NB_W'(BINS);
      end else begin
         nb = bin_count_ff;
      end
   end

   // split bins, upper raised to lower
   always_comb begin
      lo_c = (low_frac_ff > rhs_pkg::FRAC_ONE) ? rhs_pkg::FRAC_ONE : low_frac_ff;
      hi_c = (high_frac_ff > rhs_pkg::FRAC_ONE) ? rhs_pkg::FRAC_ONE : high_frac_ff;
      lo_prod = 24'(nb) * 24'(lo_c);
      hi_prod = 24'(nb) * 24'(hi_c);
      split_lo_in = lo_prod[22:16];
      split_hi_in = (hi_prod[22:16] < lo_prod[22:16]) ? lo_prod[22:16] : hi_prod[22:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff <= '0;
         range_max_ff <= 32'sd65536;
         bin_count_ff <= 7'd64;
         low_frac_ff  <= '0;
         high_frac_ff <= rhs_pkg::FRAC_ONE;
      end else begin
         range_min_ff <= range_min_in;
         range_max_ff <= range_max_in;
         bin_count_ff <= bin_count_in;
         low_frac_ff  <= low_frac_in;
         high_frac_ff <= high_frac_in;
      end
   end

   always_ff @(posedge clock) begin
      split_lo_ff <= split_lo_in;
      split_hi_ff <= split_hi_in;
   end

   assign cfg.range_min = range_min_ff;
   assign cfg.range_max = range_max_ff;
   assign cfg.nb        = nb;
   assign cfg.split_lo  = split_lo_ff;
   assign cfg.split_hi  = split_hi_ff;

endmodule

`default_nettype wire

FILE: rtl/rhs_divider.sv
`default_nettype none

module rhs_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [rhs_pkg::PROD_W-1:0]   numer,
   input  wire logic [rhs_pkg::VALUE_W-1:0]  denom,
   output logic                              done,
   output logic [rhs_pkg::QUOT_W-1:0]        quot
);

   logic [rhs_pkg::PROD_W-1:0]    rem_ff, rem_in;
   logic [rhs_pkg::PROD_W-1:0]    den_ff, den_in;
   logic [rhs_pkg::QUOT_W-1:0]    quot_ff, quot_in;
   logic [rhs_pkg::DIV_CNT_W-1:0] step_ff, step_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          fits;

   // one compare and subtract per quotient bit, msb first
   assign fits = (rem_ff >= den_ff);

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = numer;
         den_in  = rhs_pkg::PROD_W'(denom) << (rhs_pkg::QUOT_W - 1);
         quot_in = '0;
         step_in = rhs_pkg::DIV_CNT_W'(rhs_pkg::QUOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - den_ff;
         end
         quot_in = {quot_ff[rhs_pkg::QUOT_W-2:0], fits};
         den_in  = den_ff >> 1;
         step_in = step_ff - 1'b1;
         if (step_ff == rhs_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

FILE: rtl/rhs_bin_mem.sv
`default_nettype none

module rhs_bin_mem #(
   parameter int BINS        = 64,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(BINS)-1:0]    wr_addr,
   input  wire logic [COUNT_WIDTH-1:0]     wr_data,
   input  wire logic [$clog2(BINS)-1:0]    rd_addr,
   output logic [COUNT_WIDTH-1:0]          rd_data
);

   logic [COUNT_WIDTH-1:0] count_mem [BINS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;

   // one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= count_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: verif/range_histogram_checker.sv
`timescale 1ns / 100ps

module range_histogram_checker #(
   parameter int BINS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [rhs_pkg::CMD_W-1:0]            req_command,
   input  logic signed [rhs_pkg::VALUE_W-1:0]   req_sample_value,
   input  logic [rhs_pkg::READ_BIN_W-1:0]       req_read_bin,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [rhs_pkg::OUT_W-1:0]            rsp_bin_value,
   input  logic [rhs_pkg::OUT_W-1:0]            rsp_peak_count,
   input  logic [rhs_pkg::OUT_W-1:0]            rsp_below_total,
   input  logic [rhs_pkg::OUT_W-1:0]            rsp_selected_total,
   input  logic [rhs_pkg::OUT_W-1:0]            rsp_above_total,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [rhs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rhs_pkg::VALUE_W-1:0]          csr_data,
   output int                                   fail_count,
   output int                                   pending_reads,
   output int                                   reads_checked
);

   // one read word as the histogram should report it
   typedef struct packed {
      logic [rhs_pkg::OUT_W-1:0] bin_value;
      logic [rhs_pkg::OUT_W-1:0] peak;
      logic [rhs_pkg::OUT_W-1:0] below;
      logic [rhs_pkg::OUT_W-1:0] selected;
      logic [rhs_pkg::OUT_W-1:0] above;
   } tally_type;

   // shadow configuration
   logic signed [rhs_pkg::VALUE_W-1:0] lo_edge;
   logic signed [rhs_pkg::VALUE_W-1:0] hi_edge;
   logic [rhs_pkg::NB_W-1:0]           bins_reg;
   logic [rhs_pkg::FRAC_W-1:0]         low_frac;
   logic [rhs_pkg::FRAC_W-1:0]         high_frac;

   // shadow bin memory and the reads still owed by the block
   logic [rhs_pkg::OUT_W-1:0] hist [BINS];
   tally_type                 owed_reads [$];

   initial begin
      fail_count    = 0;
      pending_reads = 0;
      reads_checked = 0;
   end

   task automatic flag_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [rhs_pkg::OUT_W-1:0] got,
                              input logic [rhs_pkg::OUT_W-1:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // bin count clamped to at least 3 and to what the memory holds
   function automatic int unsigned bins_in_use();
      int unsigned nb;
      nb = bins_reg;
      if (nb < 3) nb = 3;
      if (nb > BINS) nb = BINS;
      return nb;
   endfunction

   function automatic int unsigned split_point(input int unsigned nb,
                                               input logic [rhs_pkg::FRAC_W-1:0] frac);
      longint unsigned f;
      f = (frac > rhs_pkg::FRAC_ONE) ? rhs_pkg::FRAC_ONE : frac;
      return int'((longint'(nb) * f) >> 16);
   endfunction

   // drop samples outside the range, else bump the bin with saturation
   task automatic bin_sample(input logic signed [rhs_pkg::VALUE_W-1:0] v);
      int unsigned     nb;
      longint unsigned span;
      longint unsigned off;
      longint unsigned idx;
      nb = bins_in_use();
      if (hi_edge <= lo_edge || v < lo_edge || v > hi_edge) return;
      span = longint'(hi_edge) - longint'(lo_edge);
      off  = longint'(v) - longint'(lo_edge);
      idx  = (off * longint'(nb - 1)) / span;
      if (idx >= nb) idx = nb - 1;
      if (hist[idx] != rhs_pkg::OUT_MAX) hist[idx] = hist[idx] + 1'b1;
   endtask

   // peak and split totals over the bins in use
   function automatic tally_type read_tally(input logic [rhs_pkg::READ_BIN_W-1:0] rb);
      tally_type       t;
      int unsigned     nb;
      int unsigned     lo;
      int unsigned     hi;
      int unsigned     i;
      longint unsigned top;
      longint unsigned below;
      longint unsigned sel;
      longint unsigned above;
      nb    = bins_in_use();
      lo    = split_point(nb, low_frac);
      hi    = split_point(nb, high_frac);
      if (hi < lo) hi = lo;
      top   = 0;
      below = 0;
      sel   = 0;
      above = 0;
      for (i = 0; i < nb; i++) begin
         if (hist[i] > top) top = hist[i];
         if (i < lo) below += hist[i];
         else if (i < hi) sel += hist[i];
         else above += hist[i];
      end
      t.bin_value = (rb < nb) ? hist[rb] : '0;
      t.peak      = top[rhs_pkg::OUT_W-1:0];
      t.below     = (below > rhs_pkg::OUT_MAX) ? rhs_pkg::OUT_MAX : below[rhs_pkg::OUT_W-1:0];
      t.selected  = (sel > rhs_pkg::OUT_MAX) ? rhs_pkg::OUT_MAX : sel[rhs_pkg::OUT_W-1:0];
      t.above     = (above > rhs_pkg::OUT_MAX) ? rhs_pkg::OUT_MAX : above[rhs_pkg::OUT_W-1:0];
      return t;
   endfunction

   always @(posedge clock) begin
      tally_type want;
      if (reset) begin
         lo_edge   = '0;
         hi_edge   = 32'sd65536;
         bins_reg  = 7'd64;
         low_frac  = '0;
         high_frac = rhs_pkg::FRAC_ONE;
         foreach (hist[i]) hist[i] = '0;
         owed_reads.delete();
      end else begin
         // compare a delivered read word with the oldest owed one
         if (rsp_valid && !rsp_stall) begin
            if (owed_reads.size() == 0) begin
               flag_mismatch("read word with nothing outstanding");
            end else begin
               want = owed_reads.pop_front();
               check_field("bin_value", rsp_bin_value, want.bin_value);
               check_field("peak_count", rsp_peak_count, want.peak);
               check_field("below_total", rsp_below_total, want.below);
               check_field("selected_total", rsp_selected_total, want.selected);
               check_field("above_total", rsp_above_total, want.above);
               reads_checked++;
            end
         end

         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rhs_pkg::CSR_RANGE_MIN: lo_edge   = csr_data;
               rhs_pkg::CSR_RANGE_MAX: hi_edge   = csr_data;
               rhs_pkg::CSR_BIN_COUNT: bins_reg  = csr_data[rhs_pkg::NB_W-1:0];
               rhs_pkg::CSR_LOW_FRAC:  low_frac  = csr_data[rhs_pkg::FRAC_W-1:0];
               rhs_pkg::CSR_HIGH_FRAC: high_frac = csr_data[rhs_pkg::FRAC_W-1:0];
               default: ;
            endcase
         end

         // accepted request words
         if (req_valid && !req_stall) begin
            case (req_command)
               rhs_pkg::CMD_CLEAR: foreach (hist[i]) hist[i] = '0;
               rhs_pkg::CMD_ADD:   bin_sample(req_sample_value);
               rhs_pkg::CMD_READ:  owed_reads.push_back(read_tally(req_read_bin));
               default: ;
            endcase
         end
      end
      pending_reads <= owed_reads.size();
   end

endmodule

FILE: verif/tb_range_histogram_with_split.sv
`timescale 1ns / 100ps

module tb_range_histogram_with_split;

   localparam int     LIMIT_CYCLES  = 600000;
   localparam int     SETTLE_CYCLES = 80;
   localparam int     IDLE_PCT      = 14;
   localparam int     PHASES        = 12;
   localparam longint VALUE_LOW     = -64'sh8000_0000;
   localparam longint VALUE_HIGH    = 64'sh7FFF_FFFF;

   // command with no effect and the first register index with no register
   localparam logic [rhs_pkg::CMD_W-1:0]     CMD_NOP   = 2'd3;
   localparam logic [rhs_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd5;

   logic                               clock;
   logic                               reset            = 1'b1;
   logic                               req_valid        = 1'b0;
   logic [rhs_pkg::CMD_W-1:0]          req_command      = rhs_pkg::CMD_CLEAR;
   logic signed [rhs_pkg::VALUE_W-1:0] req_sample_value = '0;
   logic [rhs_pkg::READ_BIN_W-1:0]     req_read_bin     = '0;
   logic                               rsp_stall        = 1'b0;
   logic                               csr_valid        = 1'b0;
   logic [rhs_pkg::CSR_IDX_W-1:0]      csr_index        = '0;
   logic [rhs_pkg::VALUE_W-1:0]        csr_data         = '0;
   logic                               calm             = 1'b0;

   wire logic                      req_stall;
   wire logic                      rsp_valid;
   wire logic [rhs_pkg::OUT_W-1:0] rsp_bin_value;
   wire logic [rhs_pkg::OUT_W-1:0] rsp_peak_count;
   wire logic [rhs_pkg::OUT_W-1:0] rsp_below_total;
   wire logic [rhs_pkg::OUT_W-1:0] rsp_selected_total;
   wire logic [rhs_pkg::OUT_W-1:0] rsp_above_total;
   wire logic                      csr_ready;

   int fail_count;
   int pending_reads;
   int reads_checked;
   int words_sent   = 0;
   int settings_run = 0;
   int cycles       = 0;

   // range and bin count currently loaded, used to aim samples and reads
   longint      cur_min  = 0;
   longint      cur_max  = 65536;
   int unsigned cur_bins = 64;

   range_histogram_with_split #(
      .BINS        (64),
      .COUNT_WIDTH (32)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_sample_value   (req_sample_value),
      .req_read_bin       (req_read_bin),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_bin_value      (rsp_bin_value),
      .rsp_peak_count     (rsp_peak_count),
      .rsp_below_total    (rsp_below_total),
      .rsp_selected_total (rsp_selected_total),
      .rsp_above_total    (rsp_above_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   range_histogram_checker #(
      .BINS (64)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_sample_value   (req_sample_value),
      .req_read_bin       (req_read_bin),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_bin_value      (rsp_bin_value),
      .rsp_peak_count     (rsp_peak_count),
      .rsp_below_total    (rsp_below_total),
      .rsp_selected_total (rsp_selected_total),
      .rsp_above_total    (rsp_above_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .pending_reads      (pending_reads),
      .reads_checked      (reads_checked)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // watchdog
   initial begin
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("range_histogram_with_split verification failed");
      $finish;
   end

   function automatic longint rand_upto(input longint unsigned r);
      longint unsigned x;
      x = {$urandom(), $urandom()};
      return longint'(x % (r + 1));
   endfunction

   function automatic logic [rhs_pkg::NB_W-1:0] pick_bins();
      case ($urandom_range(0, 9))
         0: return rhs_pkg::NB_W'($urandom_range(0, 2));
         1: return rhs_pkg::NB_W'($urandom_range(65, 127));
         2: return 7'd3;
         3: return 7'd64;
         default: return rhs_pkg::NB_W'($urandom_range(3, 24));
      endcase
   endfunction

   function automatic logic [rhs_pkg::FRAC_W-1:0] pick_frac();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return rhs_pkg::FRAC_ONE;
         2: return rhs_pkg::FRAC_W'($urandom_range(65537, 131071));
         default: return rhs_pkg::FRAC_W'($urandom_range(0, 65536));
      endcase
   endfunction

   // one request word, with a random gap in front of it
   task automatic send_word(input logic [rhs_pkg::CMD_W-1:0] cmd,
                            input logic [rhs_pkg::VALUE_W-1:0] value,
                            input logic [rhs_pkg::READ_BIN_W-1:0] bin);
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < IDLE_PCT) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_sample_value <= value;
      req_read_bin     <= bin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // wait for all owed reads, then let any clear or add finish
   task automatic drain();
      @(posedge clock);
      while (pending_reads != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [rhs_pkg::CSR_IDX_W-1:0] idx,
                          input logic [rhs_pkg::VALUE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // load a full register setting once the block is idle
   task automatic load_setting(input longint lo, input longint hi,
                               input logic [rhs_pkg::NB_W-1:0] nb,
                               input logic [rhs_pkg::FRAC_W-1:0] lf,
                               input logic [rhs_pkg::FRAC_W-1:0] hf);
      logic [rhs_pkg::VALUE_W-1:0] noise;
      req_valid <= 1'b0;
      drain();
      noise = $urandom();
      csr_put(rhs_pkg::CSR_RANGE_MIN, lo[rhs_pkg::VALUE_W-1:0]);
      csr_put(rhs_pkg::CSR_RANGE_MAX, hi[rhs_pkg::VALUE_W-1:0]);
      csr_put(rhs_pkg::CSR_BIN_COUNT, {noise[rhs_pkg::VALUE_W-1:rhs_pkg::NB_W], nb});
      noise = $urandom();
      csr_put(rhs_pkg::CSR_LOW_FRAC, {noise[rhs_pkg::VALUE_W-1:rhs_pkg::FRAC_W], lf});
      noise = $urandom();
      csr_put(rhs_pkg::CSR_HIGH_FRAC, {noise[rhs_pkg::VALUE_W-1:rhs_pkg::FRAC_W], hf});
      if ($urandom_range(0, 2) == 0)
         csr_put(CSR_SPARE + rhs_pkg::CSR_IDX_W'($urandom_range(0, 2)), $urandom());
      csr_valid <= 1'b0;
      cur_min  = lo;
      cur_max  = hi;
      cur_bins = (nb < 3) ? 3 : (nb > 64) ? 64 : nb;
      settings_run++;
   endtask

   // random range: mostly well formed, some empty or reversed
   task automatic random_setting();
      longint      span;
      longint      lo;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind < 4) span = $urandom_range(1, 300);
      else if (kind < 7) span = $urandom_range(1, 1 << 20);
      else if (kind == 7) span = rand_upto(64'hFFFF_FFFF);
      else if (kind == 8) span = -longint'($urandom_range(1, 1000));
      else span = 0;
      if (span >= 0) lo = VALUE_LOW + rand_upto(VALUE_HIGH - VALUE_LOW - span);
      else lo = VALUE_LOW - span + rand_upto(VALUE_HIGH - VALUE_LOW + span);
      load_setting(lo, lo + span, pick_bins(), pick_frac(), pick_frac());
   endtask

   // random word: mostly in-range samples and reads, some noise
   task automatic random_word();
      int unsigned                    pick;
      logic [rhs_pkg::VALUE_W-1:0]    v;
      logic [rhs_pkg::READ_BIN_W-1:0] rb;
      pick = $urandom_range(0, 99);
      v    = $urandom();
      rb   = ($urandom_range(0, 1) == 0)
             ? rhs_pkg::READ_BIN_W'($urandom_range(0, cur_bins - 1))
             : rhs_pkg::READ_BIN_W'($urandom());
      if (pick < 3) begin
         send_word(rhs_pkg::CMD_CLEAR, v, rb);
      end else if (pick < 6) begin
         send_word(CMD_NOP, v, rb);
      end else if (pick < 34) begin
         send_word(rhs_pkg::CMD_READ, v, rb);
      end else begin
         if (cur_max > cur_min && $urandom_range(0, 99) < 85) begin
            v = rhs_pkg::VALUE_W'(cur_min + rand_upto(cur_max - cur_min));
         end else begin
            case ($urandom_range(0, 5))
               0: v = rhs_pkg::VALUE_W'(cur_min);
               1: v = rhs_pkg::VALUE_W'(cur_max);
               2: v = rhs_pkg::VALUE_W'(cur_min - 1);
               3: v = rhs_pkg::VALUE_W'(cur_max + 1);
               default: ;
            endcase
         end
         send_word(rhs_pkg::CMD_ADD, v, rb);
      end
   endtask

   // stimulus and verdict
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: range edges, just outside them, unused command
      send_word(rhs_pkg::CMD_CLEAR, '0, '0);
      send_word(rhs_pkg::CMD_ADD, 32'd0, '0);
      send_word(rhs_pkg::CMD_ADD, 32'd65536, '0);
      send_word(rhs_pkg::CMD_ADD, '1, '0);
      send_word(rhs_pkg::CMD_ADD, 32'd65537, '0);
      send_word(rhs_pkg::CMD_ADD, 32'd32768, '0);
      send_word(CMD_NOP, 32'd32768, 6'd1);
      send_word(rhs_pkg::CMD_READ, '0, 6'd0);
      send_word(rhs_pkg::CMD_READ, '0, 6'd63);
      send_word(rhs_pkg::CMD_READ, '0, 6'd32);

      // full signed range, bin count too large, fraction above one, splits crossed
      load_setting(VALUE_LOW, VALUE_HIGH, 7'd127, 17'd70000, 17'd1000);
      send_word(rhs_pkg::CMD_ADD, 32'h8000_0000, '0);
      send_word(rhs_pkg::CMD_ADD, 32'h7FFF_FFFF, '0);
      send_word(rhs_pkg::CMD_ADD, 32'd0, '0);
      send_word(rhs_pkg::CMD_READ, '0, 6'd63);
      send_word(rhs_pkg::CMD_READ, '0, 6'd0);

      // empty range, bin count too small: leftover bins read as zero
      load_setting(100, 100, 7'd0, '0, rhs_pkg::FRAC_ONE);
      send_word(rhs_pkg::CMD_ADD, 32'd100, '0);
      send_word(rhs_pkg::CMD_READ, '0, 6'd63);
      send_word(rhs_pkg::CMD_READ, '0, 6'd2);

      // reversed range, bins grown back past the limit
      load_setting(200, 100, 7'd65, 17'd32768, 17'd49152);
      send_word(rhs_pkg::CMD_ADD, 32'd150, '0);
      send_word(rhs_pkg::CMD_READ, '0, 6'd63);
      send_word(rhs_pkg::CMD_CLEAR, '0, '0);
      send_word(rhs_pkg::CMD_READ, '0, 6'd0);

      // random phases, two of them without any idling
      for (int phase = 0; phase < PHASES; phase++) begin
         random_setting();
         if (phase == 4) calm <= 1'b1;
         if (phase == 6) calm <= 1'b0;
         repeat ($urandom_range(64, 92)) random_word();
      end

      req_valid <= 1'b0;
      drain();
      $display("sent %0d request words over %0d register settings", words_sent, settings_run);
      $display("checked %0d read words against the predicted histogram", reads_checked);
      if (fail_count == 0) begin
         $display("range_histogram_with_split verification clean");
      end else begin
         $display("range_histogram_with_split verification failed");
      end
      $finish;
   end

endmodule
